>>> rtl/core/rtb_pkg.sv
// Shared types, constants and decode functions for the ranging timing budget calculator.
// Used by rtb_div and ranging_timing_budget_calc; depends on nothing else.
package rtb_pkg;

  // Value widths
  localparam int MNS_W = 20;               // macro period in ns, at most 968532
  localparam int US_W  = 23;               // any 32-bit value divided by 1000
  localparam int DIV_W = 32;               // dividend and quotient width
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Macro period: (2304 * 1655 * period + 500) / 1000
  localparam logic [31:0] MNS_SCALE = 32'(2304 * 1655);
  localparam logic [31:0] MNS_ROUND = 32'd500;
  localparam logic [31:0] US_PER_MS = 32'd1000;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_1000  = 32'd274877907;
  localparam int          RECIP_SHIFT = 38;

  // Overheads in microseconds
  localparam logic [31:0] GET_START_OVH = 32'd1910;
  localparam logic [31:0] SET_START_OVH = 32'd1320;
  localparam logic [31:0] END_OVH       = 32'd960;
  localparam logic [31:0] MSRC_OVH      = 32'd660;
  localparam logic [31:0] TCC_OVH       = 32'd590;
  localparam logic [31:0] DSS_OVH       = 32'd690;
  localparam logic [31:0] PRE_OVH       = 32'd660;
  localparam logic [31:0] FINAL_OVH     = 32'd550;
  localparam logic [31:0] MIN_BUDGET    = 32'd20000;
  localparam logic [31:0] MANT_CLEAR_MASK = 32'hFFFF_FF00;

  // Step enable bit positions
  localparam int EN_MSRC  = 2;
  localparam int EN_DSS   = 3;
  localparam int EN_TCC   = 4;
  localparam int EN_PRE   = 6;
  localparam int EN_FINAL = 7;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [MNS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Pulse period in clocks: ((code + 1) * 2) mod 256
  function automatic logic [7:0] pulse_period(input logic [7:0] code);
    logic [7:0] c1;
    c1 = code + 8'd1;
    return {c1[6:0], 1'b0};
  endfunction

  // Timeout decode: ((mant << exp) mod 2^16) + 1, zero shift result for exp >= 16
  function automatic logic [15:0] unpack_timeout(input logic [15:0] code);
    logic [15:0] v;
    if (code[15:8] < 8'd16) begin
      v = {8'd0, code[7:0]} << code[11:8];
    end else begin
      v = '0;
    end
    return v + 16'd1;
  endfunction

endpackage

>>> rtl/core/rtb_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rtb_pkg for widths and request/response structs.
module rtb_div
  import rtb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [MNS_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [MNS_W-1:0]     dvs_r;

  logic [MNS_W:0] rem_sh;
  logic [MNS_W:0] rem_diff;
  logic           fits;

  // A zero divisor always fits, so the quotient comes out as all ones
  assign rem_sh   = {rem_r, quo_r[DIV_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs_r};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_diff[MNS_W-1:0] : rem_sh[MNS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> rtl/core/ranging_timing_budget_calc.sv
// Ranging timing budget calculator: get or set the measurement timing budget.
// A get, or a set that writes nothing, goes from the sum straight to the result; a set that
// encodes a new final timeout also runs the 32-step divider and up to 8 normalising
// shifts. One item at a time; in_stall is high during reset and from the transfer until the
// result is registered. Synchronous active-low reset returns the sequencer to idle and empties
// the output register. Depends on rtb_pkg and rtb_div; the multiplications share one multiply-add unit.
module ranging_timing_budget_calc
  import rtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_step_enables,
  input  logic [7:0]  in_pre_period_code,
  input  logic [7:0]  in_final_period_code,
  input  logic [7:0]  in_short_step_timeout,
  input  logic [15:0] in_pre_timeout_code,
  input  logic [15:0] in_final_timeout_code_in,
  input  logic [31:0] in_requested_budget_us,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_budget_us,
  output logic        out_accepted,
  output logic [15:0] out_new_final_timeout_code,
  output logic        out_write_final_timeout
);

  localparam int SUM_STEPS = 8;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MNS_PRE_A, S_MNS_PRE_B,
    S_MNS_FIN_A, S_MNS_FIN_B,
    S_SHORT_A,   S_SHORT_B,
    S_PRE_A,     S_PRE_B,
    S_FIN_A,     S_FIN_B,
    S_SUM,
    S_DECIDE,
    S_SCALE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PACK,
    S_DONE
  } state_t;

  state_t      state_r;
  logic [2:0]  sum_cnt_r;

  // Item fields
  logic        op_r;
  logic        tcc_r, dss_r, msrc_r, pre_r, fin_r;
  logic [7:0]  pre_p_r, fin_p_r;
  logic [8:0]  short_mclks_r;
  logic [15:0] pre_mclks_r, fin_mclks_r;
  logic [31:0] req_r;

  // Intermediate values
  logic [63:0]      prod_r;
  logic [MNS_W-1:0] mns_pre_r, mns_fin_r;
  logic [US_W-1:0]  short_us_r, pre_us_r, fin_us_r;
  logic [31:0]      total_r;
  logic [15:0]      mant_r;
  logic [3:0]       ex_r;
  logic [31:0]      res_budget_r;
  logic             res_acc_r, res_wr_r;

  // Output register
  logic        out_valid_r;
  logic [31:0] out_total_r;
  logic        out_accepted_r;
  logic [15:0] out_code_r;
  logic        out_write_r;
  logic        out_load;

  // Shared multiply-add unit
  logic [31:0] mul_a, mul_b, mul_c;
  logic [63:0] mul_p;

  logic [31:0] addend;
  logic        req_ok, room, go_div, acc_nxt;
  logic [15:0] mcount;
  logic        mant_over;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rtb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign div_req.start    = (state_r == S_DIV_GO);
  assign div_req.dividend = prod_r[31:0];
  assign div_req.divisor  = mns_fin_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    case (state_r)
      S_MNS_PRE_A: begin
        mul_a = 32'(pre_p_r);
        mul_b = MNS_SCALE;
        mul_c = MNS_ROUND;
      end
      S_MNS_FIN_A: begin
        mul_a = 32'(fin_p_r);
        mul_b = MNS_SCALE;
        mul_c = MNS_ROUND;
      end
      S_SHORT_A: begin
        mul_a = 32'(short_mclks_r);
        mul_b = 32'(mns_pre_r);
        mul_c = 32'(mns_pre_r >> 1);
      end
      S_PRE_A: begin
        mul_a = 32'(pre_mclks_r);
        mul_b = 32'(mns_pre_r);
        mul_c = 32'(mns_pre_r >> 1);
      end
      S_FIN_A: begin
        mul_a = 32'(fin_mclks_r);
        mul_b = 32'(mns_fin_r);
        mul_c = 32'(mns_fin_r >> 1);
      end
      S_MNS_PRE_B, S_MNS_FIN_B, S_SHORT_B, S_PRE_B, S_FIN_B: begin
        // divide the wrapped 32-bit value by 1000
        mul_a = prod_r[31:0];
        mul_b = RECIP_1000;
      end
      S_SCALE: begin
        mul_a = total_r;
        mul_b = US_PER_MS;
        mul_c = 32'(mns_fin_r >> 1);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // One step of the budget sum per cycle
  always_comb begin
    addend = '0;
    case (sum_cnt_r)
      3'd0: addend = tcc_r ? 32'(short_us_r) : '0;
      3'd1: addend = tcc_r ? TCC_OVH : '0;
      3'd2: addend = dss_r ? 32'({short_us_r, 1'b0}) : (msrc_r ? 32'(short_us_r) : '0);
      3'd3: addend = dss_r ? {DSS_OVH[30:0], 1'b0} : (msrc_r ? MSRC_OVH : '0);
      3'd4: addend = pre_r ? 32'(pre_us_r) : '0;
      3'd5: addend = pre_r ? PRE_OVH : '0;
      3'd6: addend = (fin_r && !op_r) ? 32'(fin_us_r) : '0;
      3'd7: addend = fin_r ? FINAL_OVH : '0;
      default: addend = '0;
    endcase
  end

  assign req_ok  = req_r >= MIN_BUDGET;
  assign room    = total_r <= req_r;
  assign go_div  = op_r && req_ok && fin_r && room;
  assign acc_nxt = !op_r || (req_ok && (!fin_r || room));

  assign mcount    = div_rsp.quotient[15:0] + (pre_r ? pre_mclks_r : 16'd0);
  assign mant_over = (32'(mant_r) & MANT_CLEAR_MASK) != '0;

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE:      if (in_valid) state_r <= S_MNS_PRE_A;
        S_MNS_PRE_A: state_r <= S_MNS_PRE_B;
        S_MNS_PRE_B: state_r <= S_MNS_FIN_A;
        S_MNS_FIN_A: state_r <= S_MNS_FIN_B;
        S_MNS_FIN_B: state_r <= S_SHORT_A;
        S_SHORT_A:   state_r <= S_SHORT_B;
        S_SHORT_B:   state_r <= S_PRE_A;
        S_PRE_A:     state_r <= S_PRE_B;
        S_PRE_B:     state_r <= S_FIN_A;
        S_FIN_A:     state_r <= S_FIN_B;
        S_FIN_B: begin
          state_r   <= S_SUM;
          sum_cnt_r <= '0;
        end
        S_SUM: begin
          sum_cnt_r <= sum_cnt_r + 1'b1;
          if (sum_cnt_r == 3'(SUM_STEPS - 1)) state_r <= S_DECIDE;
        end
        S_DECIDE:    state_r <= go_div ? S_SCALE : S_DONE;
        S_SCALE:     state_r <= S_DIV_GO;
        S_DIV_GO:    state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) state_r <= (mcount == '0) ? S_DONE : S_PACK;
        end
        S_PACK:      if (!mant_over) state_r <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            out_total_r    <= res_budget_r;
            out_accepted_r <= res_acc_r;
            out_code_r     <= res_wr_r ? {4'd0, ex_r, mant_r[7:0]} : '0;
            out_write_r    <= res_wr_r;
            state_r        <= S_IDLE;
          end
        end
        default:     state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p + {32'd0, mul_c};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_r          <= in_opcode;
          tcc_r         <= in_step_enables[EN_TCC];
          dss_r         <= in_step_enables[EN_DSS];
          msrc_r        <= in_step_enables[EN_MSRC];
          pre_r         <= in_step_enables[EN_PRE];
          fin_r         <= in_step_enables[EN_FINAL];
          pre_p_r       <= pulse_period(in_pre_period_code);
          fin_p_r       <= pulse_period(in_final_period_code);
          short_mclks_r <= {1'b0, in_short_step_timeout} + 9'd1;
          pre_mclks_r   <= unpack_timeout(in_pre_timeout_code);
          fin_mclks_r   <= unpack_timeout(in_final_timeout_code_in);
          req_r         <= in_requested_budget_us;
          total_r       <= (in_opcode ? SET_START_OVH : GET_START_OVH) + END_OVH;
        end
      end
      S_MNS_PRE_A: begin
        // final count excludes the pre-range periods
        if (pre_r) fin_mclks_r <= fin_mclks_r - pre_mclks_r;
      end
      S_MNS_FIN_A: mns_pre_r  <= prod_r[RECIP_SHIFT +: MNS_W];
      S_SHORT_A:   mns_fin_r  <= prod_r[RECIP_SHIFT +: MNS_W];
      S_PRE_A:     short_us_r <= prod_r[RECIP_SHIFT +: US_W];
      S_FIN_A:     pre_us_r   <= prod_r[RECIP_SHIFT +: US_W];
      S_SUM: begin
        // the final-range product stays in prod_r only on the first sum step
        if (sum_cnt_r == '0) fin_us_r <= prod_r[RECIP_SHIFT +: US_W];
        total_r <= total_r + addend;
      end
      S_DECIDE: begin
        res_budget_r <= op_r ? '0 : total_r;
        res_acc_r    <= acc_nxt;
        res_wr_r     <= go_div;
        total_r      <= req_r - total_r;
        mant_r       <= '0;
        ex_r         <= '0;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) mant_r <= (mcount == '0) ? '0 : mcount - 16'd1;
      end
      S_PACK: begin
        if (mant_over) begin
          mant_r <= mant_r >> 1;
          ex_r   <= ex_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall                   = !rst_n || (state_r != S_IDLE);
  assign out_valid                  = out_valid_r;
  assign out_budget_us              = out_total_r;
  assign out_accepted               = out_accepted_r;
  assign out_new_final_timeout_code = out_code_r;
  assign out_write_final_timeout    = out_write_r;

  a_write_implies_accept : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_write_r |-> out_accepted_r && (out_total_r == '0))
    else $error("timeout write without accepted set");

  a_div_only_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> state_r == S_DIV_WAIT)
    else $error("divider busy outside wait state");

  a_pack_bound : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PACK |-> ex_r <= 4'd8)
    else $error("normalising exponent out of range");

  a_transfer_starts : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_MNS_PRE_A)
    else $error("input transfer did not start the sequence");

endmodule
